/* sv/gsa_pkg.sv */
// shared constants, codes and types of the guard slot allocator
package gsa_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PAGE_W     = $clog2(PAGE_BYTES);
  // page numbers inside the managed window
  localparam int PNUM_W     = $clog2(SLOT_COUNT * 4);
  // divide-by-three reciprocal for page numbers
  localparam int DIV3_SH    = PNUM_W + 2;
  localparam int DIV3_MUL   = ((1 << DIV3_SH) + 2) / 3;
  localparam int DIV3_PW    = PNUM_W + DIV3_SH + 1;

  localparam logic [63:0] GUARD_BASE   = 64'hFFFF_B000_0000_0000;
  localparam logic [63:0] WINDOW_BYTES = 64'(SLOT_COUNT) * 64'd4 * 64'(PAGE_BYTES);
  localparam logic [63:0] STRIDE       = 64'd3 * 64'(PAGE_BYTES);

  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 8'd1;
  localparam logic [15:0]          RATE_RESET      = 16'd1024;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_ALLOC = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_FAULT = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    RES_OK      = 3'd0,
    RES_DECLINE = 3'd1,
    RES_NO_SLOT = 3'd2,
    RES_NO_FRM  = 3'd3,
    RES_FATAL   = 3'd4
  } res_t;

  typedef enum logic [2:0] {
    FK_NONE     = 3'd0,
    FK_UAF      = 3'd1,
    FK_OVERFLOW = 3'd2,
    FK_UNDERFLW = 3'd3,
    FK_GUARD    = 3'd4,
    FK_UNALLOC  = 3'd5,
    FK_BAD_FREE = 3'd6
  } fkind_t;

  typedef enum logic [1:0] {
    SL_FREE   = 2'd0,
    SL_ACTIVE = 2'd1,
    SL_FREED  = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DIV,
    ST_FIN
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_en;
    logic div_start;
    logic div_step;
    logic fault_latch;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       enable;
    logic       size_ok;
    logic       managed;
    logic       scan_match;
    logic       scan_last;
    logic       div_last;
    logic       out_busy;
  } sts_t;

  // user pointer of an object in a slot
  function automatic logic [63:0] obj_addr(input logic [SLOT_W-1:0] idx,
                                           input logic [PAGE_W-1:0] off);
    obj_addr = GUARD_BASE + 64'(idx) * STRIDE + 64'(PAGE_BYTES) + 64'(off);
  endfunction

endpackage

/* sv/gsa_in_if.sv */
// request, result and register write channels
interface gsa_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] address;
  logic [31:0] alloc_size;
  logic [63:0] caller_id;
  logic        frame_available;
  modport source (output valid, command, address, alloc_size, caller_id,
                  frame_available, input ready);
  modport sink (input valid, command, address, alloc_size, caller_id,
                frame_available, output ready);
endinterface

interface gsa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  fault_kind;
  logic [63:0] object_address;
  logic [15:0] object_size;
  logic [7:0]  slot_index;
  logic [63:0] owner_caller;
  logic [63:0] freeing_caller;
  logic [63:0] sampled_count;
  logic [63:0] overflow_count;
  logic [63:0] uaf_count;
  modport source (output valid, status, fault_kind, object_address, object_size,
                  slot_index, owner_caller, freeing_caller, sampled_count,
                  overflow_count, uaf_count, input ready);
  modport sink (input valid, status, fault_kind, object_address, object_size,
                slot_index, owner_caller, freeing_caller, sampled_count,
                overflow_count, uaf_count, output ready);
endinterface

interface gsa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gsa_pkg::CFG_IDX_W-1:0]     index;
  logic [gsa_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/guard_slot_allocator.sv */
// Guarded sampling slot table: one request beat gives one result beat. A request is
// taken in IDLE, decoded in EXEC and finished in FIN; allocate, free and size query
// add a scan of the slot table at one slot a cycle (stopping at the first match or
// the last slot), and an enabled sample tick adds a pass of the bit-serial remainder
// unit that tests the tick counter against the sample rate. The result sits in an
// output register; a new request is taken once the previous one has been placed
// there. Register writes are taken in any cycle and belong between requests. The
// table needs no clearing pass after reset.
module guard_slot_allocator (
  input  logic       clk,
  input  logic       rst_n,
  gsa_in_if.sink     in_if,
  gsa_out_if.source  out_if,
  gsa_cfg_if.sink    cfg_if
);

  gsa_pkg::ctl_t ctl;
  gsa_pkg::sts_t sts;

  // sequencer
  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // table and arithmetic
  gsa_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .ctl    (ctl),
    .sts    (sts)
  );

endmodule

/* sv/gsa_ctrl.sv */
// sequencing state machine of the guard slot allocator
module gsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gsa_pkg::sts_t  sts,
  output gsa_pkg::ctl_t  ctl
);

  gsa_pkg::fsm_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gsa_pkg::ST_EXEC;
      end
      gsa_pkg::ST_EXEC: begin
        state_nxt = gsa_pkg::ST_FIN;
        case (sts.cmd)
          gsa_pkg::CMD_TICK:  if (sts.enable) state_nxt = gsa_pkg::ST_DIV;
          gsa_pkg::CMD_ALLOC: if (sts.enable && sts.size_ok) state_nxt = gsa_pkg::ST_SCAN;
          gsa_pkg::CMD_FREE,
          gsa_pkg::CMD_QUERY: if (sts.managed) state_nxt = gsa_pkg::ST_SCAN;
          default:            state_nxt = gsa_pkg::ST_FIN;
        endcase
      end
      gsa_pkg::ST_SCAN: begin
        if (sts.scan_match || sts.scan_last) state_nxt = gsa_pkg::ST_FIN;
      end
      gsa_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = gsa_pkg::ST_FIN;
      end
      gsa_pkg::ST_FIN: begin
        if (!sts.out_busy) state_nxt = gsa_pkg::ST_IDLE;
      end
      default: state_nxt = gsa_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    case (state_r)
      gsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      gsa_pkg::ST_EXEC: begin
        ctl.scan_start  = 1'b1;
        ctl.div_start   = 1'b1;
        ctl.fault_latch = 1'b1;
      end
      gsa_pkg::ST_SCAN: ctl.scan_en  = 1'b1;
      gsa_pkg::ST_DIV:  ctl.div_step = 1'b1;
      gsa_pkg::ST_FIN:  ctl.finish   = !sts.out_busy;
      default: ctl = '0;
    endcase
  end

endmodule

/* sv/gsa_dp.sv */
// slot table, counters, remainder unit and result register
module gsa_dp (
  input  logic           clk,
  input  logic           rst_n,
  gsa_in_if.sink         in_if,
  gsa_out_if.source      out_if,
  gsa_cfg_if.sink        cfg_if,
  input  gsa_pkg::ctl_t  ctl,
  output gsa_pkg::sts_t  sts
);

  localparam int SW = gsa_pkg::SLOT_W;
  localparam int PW = gsa_pkg::PAGE_W;
  localparam int NW = gsa_pkg::PNUM_W;

  // latched request
  logic [2:0]  cmd_r;
  logic [63:0] addr_r;
  logic [31:0] size_r;
  logic [63:0] caller_r;
  logic        frame_r;

  // registers and counters
  logic        enable_r;
  logic [15:0] rate_r;
  logic [31:0] tick_cnt_r;
  logic [63:0] alloc_tot_r, ovf_tot_r, uaf_tot_r;

  // slot table
  gsa_pkg::slot_st_t slot_st_r [gsa_pkg::SLOT_COUNT];
  logic [PW-1:0]     off_mem   [gsa_pkg::SLOT_COUNT];
  logic [PW-1:0]     size_mem  [gsa_pkg::SLOT_COUNT];
  logic [63:0]       acall_mem [gsa_pkg::SLOT_COUNT];
  logic [63:0]       fcall_mem [gsa_pkg::SLOT_COUNT];

  logic [SW-1:0] scan_r, hit_idx_r;
  logic          hit_r;
  logic          fidx_ok_r;
  logic [1:0]    fpage_r;

  // remainder unit
  logic [31:0]                 dvd_r;
  logic [15:0]                 rem_r;
  logic [gsa_pkg::DIV_CW-1:0]  div_cnt_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  o_status_r, o_kind_r;
  logic [63:0] o_addr_r, o_acall_r, o_fcall_r;
  logic [15:0] o_size_r;
  logic [7:0]  o_idx_r;

  // address decode
  logic [63:0]              off64;
  logic                     managed;
  logic [NW-1:0]            pnum;
  logic [gsa_pkg::DIV3_PW-1:0] prod;
  logic [NW-1:0]            fidx;
  logic [1:0]               fpage;
  logic                     size_ok;

  assign off64   = addr_r - gsa_pkg::GUARD_BASE;
  assign managed = (addr_r >= gsa_pkg::GUARD_BASE) && (off64 < gsa_pkg::WINDOW_BYTES);
  assign pnum    = off64[PW +: NW];
  assign prod    = gsa_pkg::DIV3_PW'(pnum) * gsa_pkg::DIV3_PW'(gsa_pkg::DIV3_MUL);
  assign fidx    = prod[gsa_pkg::DIV3_SH +: NW];
  assign fpage   = 2'(pnum - NW'(fidx * NW'(3)));
  assign size_ok = (size_r != 32'd0) && (size_r < 32'(gsa_pkg::PAGE_BYTES));

  // table read port, one address
  logic [SW-1:0] rd_idx;
  logic [PW-1:0] rd_off, rd_size;
  logic [63:0]   rd_acall, rd_fcall;
  logic [63:0]   rd_addr;
  assign rd_idx   = ctl.scan_en ? scan_r : hit_idx_r;
  assign rd_off   = off_mem[rd_idx];
  assign rd_size  = size_mem[rd_idx];
  assign rd_acall = acall_mem[rd_idx];
  assign rd_fcall = fcall_mem[rd_idx];
  assign rd_addr  = gsa_pkg::obj_addr(rd_idx, rd_off);

  // scan compare
  logic scan_match;
  always_comb begin
    if (cmd_r == gsa_pkg::CMD_ALLOC) begin
      scan_match = (slot_st_r[scan_r] == gsa_pkg::SL_FREE);
    end else begin
      scan_match = (slot_st_r[scan_r] == gsa_pkg::SL_ACTIVE) && (rd_addr == addr_r);
    end
  end

  // remainder step
  logic [15:0] rate_eff;
  logic [16:0] trial;
  assign rate_eff = (rate_r == 16'd0) ? 16'd1 : rate_r;
  assign trial    = {rem_r, dvd_r[31]};

  // new object placement
  logic [PW-1:0] new_off;
  assign new_off = PW'((32'(gsa_pkg::PAGE_BYTES) - size_r) & ~32'h7);

  // result of the step
  logic [2:0]  r_status, r_kind;
  logic [63:0] r_addr, r_acall, r_fcall;
  logic [15:0] r_size;
  logic [7:0]  r_idx;
  logic [31:0] tick_nxt;
  logic [63:0] alloc_nxt, ovf_nxt, uaf_nxt;
  logic        wr_alloc, wr_free;
  logic        put_slot;

  always_comb begin
    r_status  = gsa_pkg::RES_DECLINE;
    r_kind    = gsa_pkg::FK_NONE;
    r_idx     = 8'd0;
    put_slot  = 1'b0;
    tick_nxt  = tick_cnt_r;
    alloc_nxt = alloc_tot_r;
    ovf_nxt   = ovf_tot_r;
    uaf_nxt   = uaf_tot_r;
    wr_alloc  = 1'b0;
    wr_free   = 1'b0;
    case (cmd_r)
      gsa_pkg::CMD_TICK: begin
        if (enable_r) begin
          tick_nxt = tick_cnt_r + 32'd1;
          r_status = (rem_r == 16'd0) ? gsa_pkg::RES_OK : gsa_pkg::RES_DECLINE;
        end
      end
      gsa_pkg::CMD_ALLOC: begin
        if (enable_r && size_ok) begin
          if (!hit_r) begin
            r_status = gsa_pkg::RES_NO_SLOT;
          end else if (!frame_r) begin
            r_status = gsa_pkg::RES_NO_FRM;
          end else begin
            r_status  = gsa_pkg::RES_OK;
            wr_alloc  = 1'b1;
            alloc_nxt = alloc_tot_r + 64'd1;
          end
        end
      end
      gsa_pkg::CMD_FREE: begin
        if (managed) begin
          if (!hit_r) begin
            uaf_nxt  = uaf_tot_r + 64'd1;
            r_status = gsa_pkg::RES_FATAL;
            r_kind   = gsa_pkg::FK_BAD_FREE;
          end else begin
            r_status = gsa_pkg::RES_OK;
            wr_free  = 1'b1;
            put_slot = 1'b1;
          end
        end
      end
      gsa_pkg::CMD_FAULT: begin
        if (enable_r && managed && fidx_ok_r) begin
          r_status = gsa_pkg::RES_FATAL;
          case (slot_st_r[hit_idx_r])
            gsa_pkg::SL_FREED: begin
              uaf_nxt  = uaf_tot_r + 64'd1;
              r_kind   = gsa_pkg::FK_UAF;
              put_slot = 1'b1;
            end
            gsa_pkg::SL_ACTIVE: begin
              ovf_nxt  = ovf_tot_r + 64'd1;
              put_slot = 1'b1;
              if (fpage_r == 2'd2) begin
                r_kind = gsa_pkg::FK_OVERFLOW;
              end else if (fpage_r == 2'd0) begin
                r_kind = gsa_pkg::FK_UNDERFLW;
              end else begin
                r_kind = gsa_pkg::FK_GUARD;
              end
            end
            default: begin
              r_kind = gsa_pkg::FK_UNALLOC;
              r_idx  = 8'(hit_idx_r);
            end
          endcase
        end
      end
      gsa_pkg::CMD_QUERY: begin
        if (managed && hit_r) begin
          r_status = gsa_pkg::RES_OK;
          put_slot = 1'b1;
        end
      end
      default: r_status = gsa_pkg::RES_DECLINE;
    endcase

    // slot fields
    if (wr_alloc) begin
      r_addr  = gsa_pkg::obj_addr(hit_idx_r, new_off);
      r_size  = 16'(size_r[PW-1:0]);
      r_idx   = 8'(hit_idx_r);
      r_acall = caller_r;
      r_fcall = 64'd0;
    end else if (put_slot) begin
      r_addr  = rd_addr;
      r_size  = 16'(rd_size);
      r_idx   = 8'(hit_idx_r);
      r_acall = rd_acall;
      r_fcall = wr_free ? caller_r : rd_fcall;
    end else begin
      r_addr  = 64'd0;
      r_size  = 16'd0;
      r_acall = 64'd0;
      r_fcall = 64'd0;
    end
  end

  // request latch and configuration
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= in_if.command;
      addr_r   <= in_if.address;
      size_r   <= in_if.alloc_size;
      caller_r <= in_if.caller_id;
      frame_r  <= in_if.frame_available;
    end
    if (!rst_n) begin
      enable_r <= 1'b0;
      rate_r   <= gsa_pkg::RATE_RESET;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == gsa_pkg::REG_ENABLE)      enable_r <= cfg_if.data[0];
      if (cfg_if.index == gsa_pkg::REG_SAMPLE_RATE) rate_r   <= cfg_if.data;
    end
  end

  // scan and fault slot selection
  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      scan_r <= '0;
      hit_r  <= 1'b0;
    end else if (ctl.scan_en) begin
      if (scan_match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= scan_r;
      end else if (scan_r != SW'(gsa_pkg::SLOT_COUNT - 1)) begin
        scan_r <= scan_r + SW'(1);
      end
    end
    if (ctl.fault_latch) begin
      fidx_ok_r <= (fidx < NW'(gsa_pkg::SLOT_COUNT));
      fpage_r   <= fpage;
      hit_idx_r <= SW'(fidx);
    end
  end

  // remainder unit, one bit a cycle
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      dvd_r     <= tick_cnt_r;
      rem_r     <= 16'd0;
      div_cnt_r <= '0;
    end else if (ctl.div_step) begin
      dvd_r     <= {dvd_r[30:0], 1'b0};
      rem_r     <= (trial >= {1'b0, rate_eff}) ? 16'(trial - {1'b0, rate_eff})
                                               : trial[15:0];
      div_cnt_r <= div_cnt_r + gsa_pkg::DIV_CW'(1);
    end
  end

  // slot state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gsa_pkg::SLOT_COUNT; i++) slot_st_r[i] <= gsa_pkg::SL_FREE;
      tick_cnt_r  <= 32'd0;
      alloc_tot_r <= 64'd0;
      ovf_tot_r   <= 64'd0;
      uaf_tot_r   <= 64'd0;
    end else if (ctl.finish) begin
      if (wr_alloc) slot_st_r[hit_idx_r] <= gsa_pkg::SL_ACTIVE;
      if (wr_free)  slot_st_r[hit_idx_r] <= gsa_pkg::SL_FREED;
      tick_cnt_r  <= tick_nxt;
      alloc_tot_r <= alloc_nxt;
      ovf_tot_r   <= ovf_nxt;
      uaf_tot_r   <= uaf_nxt;
    end
  end

  // slot payload store
  always_ff @(posedge clk) begin
    if (ctl.finish && wr_alloc) begin
      off_mem[hit_idx_r]   <= new_off;
      size_mem[hit_idx_r]  <= size_r[PW-1:0];
      acall_mem[hit_idx_r] <= caller_r;
      fcall_mem[hit_idx_r] <= 64'd0;
    end
    if (ctl.finish && wr_free) begin
      fcall_mem[hit_idx_r] <= caller_r;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctl.finish) begin
      o_status_r <= r_status;
      o_kind_r   <= r_kind;
      o_addr_r   <= r_addr;
      o_size_r   <= r_size;
      o_idx_r    <= r_idx;
      o_acall_r  <= r_acall;
      o_fcall_r  <= r_fcall;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = o_status_r;
  assign out_if.fault_kind     = o_kind_r;
  assign out_if.object_address = o_addr_r;
  assign out_if.object_size    = o_size_r;
  assign out_if.slot_index     = o_idx_r;
  assign out_if.owner_caller   = o_acall_r;
  assign out_if.freeing_caller = o_fcall_r;
  assign out_if.sampled_count  = alloc_tot_r;
  assign out_if.overflow_count = ovf_tot_r;
  assign out_if.uaf_count      = uaf_tot_r;

  // status to controller
  assign sts.cmd        = cmd_r;
  assign sts.enable     = enable_r;
  assign sts.size_ok    = size_ok;
  assign sts.managed    = managed;
  assign sts.scan_match = scan_match;
  assign sts.scan_last  = (scan_r == SW'(gsa_pkg::SLOT_COUNT - 1));
  assign sts.div_last   = (div_cnt_r == gsa_pkg::DIV_CW'(gsa_pkg::DIV_STEPS - 1));
  assign sts.out_busy   = out_valid_r && !out_if.ready;

endmodule

/* dv/tb_top.sv */
// self-checking testbench for the guard slot allocator
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] WIN_END    = gsa_pkg::GUARD_BASE + gsa_pkg::WINDOW_BYTES;
  localparam int          STALL_LIMIT = 5000;

  // aiming of addresses, resolved when the beat is driven
  localparam logic [1:0] AIM_NONE   = 2'd0;
  localparam logic [1:0] AIM_OBJECT = 2'd1;
  localparam logic [1:0] AIM_SLOT   = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] addr;
    logic [31:0] size;
    logic [63:0] caller;
    logic        frame;
    logic [1:0]  aim;
    logic        drain;
  } request_t;

  typedef struct packed {
    gsa_pkg::res_t   st;
    gsa_pkg::fkind_t kind;
    logic [63:0] obj_addr;
    logic [15:0] obj_size;
    logic [7:0]  slot;
    logic [63:0] a_caller;
    logic [63:0] f_caller;
    logic [63:0] n_sampled;
    logic [63:0] n_overflow;
    logic [63:0] n_uaf;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gsa_in_if  in_bus();
  gsa_out_if out_bus();
  gsa_cfg_if cfg_bus();

  guard_slot_allocator dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus),
    .cfg_if(cfg_bus)
  );

  always #5 clk = ~clk;

  // shadow of the slot table and counters
  gsa_pkg::slot_st_t tab_state [gsa_pkg::SLOT_COUNT];
  logic [11:0] tab_off [gsa_pkg::SLOT_COUNT];
  logic [11:0] tab_size [gsa_pkg::SLOT_COUNT];
  logic [63:0] tab_acaller [gsa_pkg::SLOT_COUNT];
  logic [63:0] tab_fcaller [gsa_pkg::SLOT_COUNT];
  logic [31:0] tick_count;
  logic [63:0] sampled_total, overflow_total, uaf_total;
  logic        en_reg;
  logic [15:0] rate_reg;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int  beats_in, beats_out, mismatches, idle_cycles;
  logic in_fire;
  int  burst_left, gap_left;
  int  hold_left, stall_mode, stall_window;
  bit  hold_done;

  function automatic logic [63:0] data_page(input int s);
    return gsa_pkg::GUARD_BASE + 64'(s) * gsa_pkg::STRIDE + 64'(gsa_pkg::PAGE_BYTES);
  endfunction

  function automatic int find_active(input logic [63:0] a);
    for (int i = 0; i < gsa_pkg::SLOT_COUNT; i++)
      if (tab_state[i] == gsa_pkg::SL_ACTIVE && data_page(i) + 64'(tab_off[i]) == a)
        return i;
    return -1;
  endfunction

  function automatic void load_slot(inout outcome_t o, input int s);
    o.obj_addr = data_page(s) + 64'(tab_off[s]);
    o.obj_size = 16'(tab_size[s]);
    o.slot     = 8'(s);
    o.a_caller = tab_acaller[s];
    o.f_caller = tab_fcaller[s];
  endfunction

  // expected outcome of one request; updates the shadow state
  function automatic outcome_t predict_outcome(input request_t r);
    outcome_t o;
    logic [31:0] eff_rate;
    logic [63:0] dp, u, off, idx, page_off;
    int s;
    o = '0;
    o.st = gsa_pkg::RES_DECLINE;
    o.kind = gsa_pkg::FK_NONE;
    case (r.cmd)
      gsa_pkg::CMD_TICK: if (en_reg) begin
        eff_rate = (rate_reg == 16'd0) ? 32'd1 : 32'(rate_reg);
        o.st = (tick_count % eff_rate == 0) ? gsa_pkg::RES_OK : gsa_pkg::RES_DECLINE;
        tick_count = tick_count + 32'd1;
      end
      gsa_pkg::CMD_ALLOC: if (en_reg && r.size != 0 && r.size < gsa_pkg::PAGE_BYTES) begin
        s = -1;
        for (int i = 0; i < gsa_pkg::SLOT_COUNT; i++)
          if (s < 0 && tab_state[i] == gsa_pkg::SL_FREE) s = i;
        if (s < 0) o.st = gsa_pkg::RES_NO_SLOT;
        else if (!r.frame) o.st = gsa_pkg::RES_NO_FRM;
        else begin
          dp = data_page(s);
          u = (dp + 64'(gsa_pkg::PAGE_BYTES) - 64'(r.size)) & ~64'h7;
          if (u < dp) u = dp;
          tab_off[s] = 12'(u - dp);
          tab_size[s] = 12'(r.size);
          tab_acaller[s] = r.caller;
          tab_fcaller[s] = '0;
          tab_state[s] = gsa_pkg::SL_ACTIVE;
          sampled_total++;
          o.st = gsa_pkg::RES_OK;
          load_slot(o, s);
        end
      end
      gsa_pkg::CMD_FREE: if (r.addr >= gsa_pkg::GUARD_BASE && r.addr < WIN_END) begin
        s = find_active(r.addr);
        if (s < 0) begin
          uaf_total++;
          o.st = gsa_pkg::RES_FATAL;
          o.kind = gsa_pkg::FK_BAD_FREE;
        end else begin
          tab_fcaller[s] = r.caller;
          tab_state[s] = gsa_pkg::SL_FREED;
          o.st = gsa_pkg::RES_OK;
          load_slot(o, s);
        end
      end
      gsa_pkg::CMD_FAULT: if (en_reg && r.addr >= gsa_pkg::GUARD_BASE && r.addr < WIN_END)
      begin
        off = r.addr - gsa_pkg::GUARD_BASE;
        idx = off / gsa_pkg::STRIDE;
        page_off = off % gsa_pkg::STRIDE;
        if (idx < gsa_pkg::SLOT_COUNT) begin
          o.st = gsa_pkg::RES_FATAL;
          if (tab_state[idx] == gsa_pkg::SL_FREED) begin
            uaf_total++;
            o.kind = gsa_pkg::FK_UAF;
            load_slot(o, int'(idx));
          end else if (tab_state[idx] == gsa_pkg::SL_ACTIVE) begin
            overflow_total++;
            if (page_off >= 2 * gsa_pkg::PAGE_BYTES) o.kind = gsa_pkg::FK_OVERFLOW;
            else if (page_off < gsa_pkg::PAGE_BYTES) o.kind = gsa_pkg::FK_UNDERFLW;
            else o.kind = gsa_pkg::FK_GUARD;
            load_slot(o, int'(idx));
          end else begin
            o.kind = gsa_pkg::FK_UNALLOC;
            o.slot = 8'(idx);
          end
        end
      end
      gsa_pkg::CMD_QUERY: if (r.addr >= gsa_pkg::GUARD_BASE && r.addr < WIN_END) begin
        s = find_active(r.addr);
        if (s >= 0) begin
          o.st = gsa_pkg::RES_OK;
          load_slot(o, s);
        end
      end
      default: ;
    endcase
    o.n_sampled = sampled_total;
    o.n_overflow = overflow_total;
    o.n_uaf = uaf_total;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: checks result beats, predicts request beats, tracks register writes
  always @(posedge clk) begin
    outcome_t w;
    logic any_beat;
    any_beat = 1'b0;
    in_fire <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        any_beat = 1'b1;
        if (cfg_bus.index == gsa_pkg::REG_ENABLE) en_reg = cfg_bus.data[0];
        else if (cfg_bus.index == gsa_pkg::REG_SAMPLE_RATE) rate_reg = cfg_bus.data;
      end
      if (out_bus.valid && out_bus.ready) begin
        any_beat = 1'b1;
        beats_out++;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d", $realtime,
                   out_bus.status);
          mismatches++;
        end else begin
          w = expected_outcomes.pop_front();
          check_field("status", 64'(w.st), 64'(out_bus.status));
          check_field("fault_kind", 64'(w.kind), 64'(out_bus.fault_kind));
          check_field("object_address", w.obj_addr, out_bus.object_address);
          check_field("object_size", 64'(w.obj_size), 64'(out_bus.object_size));
          check_field("slot_index", 64'(w.slot), 64'(out_bus.slot_index));
          check_field("owner_caller", w.a_caller, out_bus.owner_caller);
          check_field("freeing_caller", w.f_caller, out_bus.freeing_caller);
          check_field("sampled_count", w.n_sampled, out_bus.sampled_count);
          check_field("overflow_count", w.n_overflow, out_bus.overflow_count);
          check_field("uaf_count", w.n_uaf, out_bus.uaf_count);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        any_beat = 1'b1;
        beats_in++;
        expected_outcomes.push_back(predict_outcome('{in_bus.command, in_bus.address,
          in_bus.alloc_size, in_bus.caller_id, in_bus.frame_available, AIM_NONE, 1'b0}));
      end
      idle_cycles <= any_beat ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // request driver: bursts with random gaps, addresses aimed at table objects or random slots
  always @(negedge clk) begin
    request_t r;
    int pick, n;
    int used [$];
    if (rst_n && (!in_bus.valid || in_fire)) begin
      if (gap_left > 0) begin
        in_bus.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain && expected_outcomes.size() != 0)) begin
        in_bus.valid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        used.delete();
        if (r.aim == AIM_OBJECT) begin
          for (int i = 0; i < gsa_pkg::SLOT_COUNT; i++)
            if (tab_state[i] != gsa_pkg::SL_FREE) used.push_back(i);
          if (used.size() > 0) begin
            pick = used[$urandom_range(used.size() - 1)];
            r.addr = data_page(pick) + 64'(tab_off[pick]);
          end
        end else if (r.aim == AIM_SLOT) begin
          r.addr = gsa_pkg::GUARD_BASE
                   + 64'($urandom_range(gsa_pkg::SLOT_COUNT - 1)) * gsa_pkg::STRIDE
                   + 64'($urandom_range(3 * gsa_pkg::PAGE_BYTES - 1));
        end
        in_bus.valid <= 1'b1;
        in_bus.command <= r.cmd;
        in_bus.address <= r.addr;
        in_bus.alloc_size <= r.size;
        in_bus.caller_id <= r.caller;
        in_bus.frame_available <= r.frame;
        if (burst_left <= 1) begin
          n = $urandom_range(3);
          gap_left <= (n == 0) ? 0 : $urandom_range(8);
          burst_left <= $urandom_range(1, 24);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // result receiver: own stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && beats_in >= 600) begin
        hold_done <= 1'b1;
        hold_left <= 250;
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        if (stall_window == 0) begin
          stall_mode <= $urandom_range(2);
          stall_window <= $urandom_range(8, 64);
        end else begin
          stall_window <= stall_window - 1;
        end
        out_bus.ready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(99) < 60);
      end
    end
  end

  function automatic request_t make_req(input logic [2:0] cmd, input logic [63:0] addr,
                                        input logic [31:0] size, input logic frame,
                                        input logic [1:0] aim);
    return '{cmd, addr, size, {$urandom, $urandom}, frame, aim, 1'b0};
  endfunction

  function automatic request_t random_req();
    int roll;
    logic [31:0] size;
    roll = $urandom_range(99);
    case ($urandom_range(9))
      0: size = 32'd0;
      1: size = {$urandom} | 32'h1000;
      2: size = 32'(gsa_pkg::PAGE_BYTES);
      default: size = $urandom_range(1, gsa_pkg::PAGE_BYTES - 1);
    endcase
    if (roll < 15)
      return make_req(gsa_pkg::CMD_TICK, {$urandom, $urandom}, $urandom, 1'b1, AIM_NONE);
    if (roll < 40)
      return make_req(gsa_pkg::CMD_ALLOC, {$urandom, $urandom}, size,
                      $urandom_range(9) != 0, AIM_NONE);
    if (roll < 58)
      return make_req(gsa_pkg::CMD_FREE, ($urandom_range(3) == 0) ? {$urandom, $urandom} :
                      gsa_pkg::GUARD_BASE + 64'($urandom_range(gsa_pkg::WINDOW_BYTES - 1)),
                      $urandom, 1'b1, ($urandom_range(3) != 0) ? AIM_OBJECT : AIM_NONE);
    if (roll < 76)
      return make_req(gsa_pkg::CMD_FAULT, ($urandom_range(3) == 0) ? {$urandom, $urandom} :
                      gsa_pkg::GUARD_BASE + 64'($urandom_range(gsa_pkg::WINDOW_BYTES - 1)),
                      $urandom, 1'b1, ($urandom_range(2) != 0) ? AIM_SLOT : AIM_NONE);
    if (roll < 94)
      return make_req(gsa_pkg::CMD_QUERY,
                      gsa_pkg::GUARD_BASE + 64'($urandom_range(gsa_pkg::WINDOW_BYTES - 1)),
                      $urandom, 1'b1, ($urandom_range(3) != 0) ? AIM_OBJECT : AIM_NONE);
    return make_req(3'($urandom_range(5, 7)), {$urandom, $urandom}, $urandom,
                    $urandom_range(1), AIM_NONE);
  endfunction

  task automatic write_reg(input logic [gsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_bus.valid || expected_outcomes.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_random(input int count, input logic [15:0] rate);
    request_t r;
    write_reg(gsa_pkg::REG_ENABLE, 16'd1);
    write_reg(gsa_pkg::REG_SAMPLE_RATE, rate);
    for (int i = 0; i < count; i++) begin
      r = random_req();
      r.drain = (i == count / 2);
      pending_reqs.push_back(r);
    end
    wait_idle();
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.command = gsa_pkg::CMD_TICK;
    in_bus.address = '0;
    in_bus.alloc_size = '0;
    in_bus.caller_id = '0;
    in_bus.frame_available = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = gsa_pkg::REG_ENABLE;
    cfg_bus.data = '0;
    for (int i = 0; i < gsa_pkg::SLOT_COUNT; i++) begin
      tab_state[i] = gsa_pkg::SL_FREE;
      tab_off[i] = '0;
      tab_size[i] = '0;
      tab_acaller[i] = '0;
      tab_fcaller[i] = '0;
    end
    tick_count = '0;
    sampled_total = '0;
    overflow_total = '0;
    uaf_total = '0;
    en_reg = 1'b0;
    rate_reg = gsa_pkg::RATE_RESET;
    in_fire = 1'b0;
    beats_in = 0;
    beats_out = 0;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    stall_mode = 0;
    stall_window = 0;
    hold_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // disabled block: only free and size query do anything
    pending_reqs.push_back(make_req(gsa_pkg::CMD_TICK, '0, 32'd1, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_ALLOC, '0, 32'd16, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FAULT, gsa_pkg::GUARD_BASE, 32'd0, 1'b1,
                                    AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FREE, gsa_pkg::GUARD_BASE + 64'd5000,
                                    32'd0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FREE, '1, 32'd0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_QUERY, gsa_pkg::GUARD_BASE, 32'd0, 1'b1,
                                    AIM_NONE));
    wait_idle();

    // directed: sizes at the edges, every command, every fault class
    write_reg(gsa_pkg::REG_ENABLE, 16'd1);
    write_reg(gsa_pkg::REG_SAMPLE_RATE, 16'd1);
    pending_reqs.push_back(make_req(gsa_pkg::CMD_TICK, '0, '0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_ALLOC, '0, 32'd1, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_ALLOC, '0, 32'(gsa_pkg::PAGE_BYTES - 1),
                                    1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_ALLOC, '0, 32'd0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_ALLOC, '0, 32'(gsa_pkg::PAGE_BYTES), 1'b1,
                                    AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_ALLOC, '0, '1, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_ALLOC, '0, 32'd8, 1'b0, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_QUERY, '0, '0, 1'b1, AIM_OBJECT));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_QUERY, 64'd12, '0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FAULT, gsa_pkg::GUARD_BASE + 64'd7, '0,
                                    1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FAULT,
                                    gsa_pkg::GUARD_BASE + 64'(gsa_pkg::PAGE_BYTES + 10), '0,
                                    1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FAULT,
                                    gsa_pkg::GUARD_BASE + 64'(2 * gsa_pkg::PAGE_BYTES + 5),
                                    '0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FAULT, gsa_pkg::GUARD_BASE
                                    + 64'(gsa_pkg::SLOT_COUNT - 1) * gsa_pkg::STRIDE,
                                    '0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FAULT, gsa_pkg::GUARD_BASE
                                    + 64'(gsa_pkg::SLOT_COUNT) * gsa_pkg::STRIDE + 64'd9,
                                    '0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FAULT, WIN_END, '0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FREE,
                                    data_page(0) + 64'(gsa_pkg::PAGE_BYTES - 8), '0, 1'b1,
                                    AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FREE,
                                    data_page(0) + 64'(gsa_pkg::PAGE_BYTES - 8), '0, 1'b1,
                                    AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FAULT, data_page(0), '0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(gsa_pkg::CMD_FREE, gsa_pkg::GUARD_BASE - 64'd1, '0,
                                    1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(3'd5, '0, '0, 1'b1, AIM_NONE));
    pending_reqs.push_back(make_req(3'd7, '1, '1, 1'b1, AIM_NONE));
    wait_idle();

    // random phases over several rate settings, extremes included
    run_random(350, 16'd3);
    run_random(350, 16'd0);
    run_random(350, 16'hFFFF);
    write_reg(gsa_pkg::REG_ENABLE, 16'd0);
    for (int i = 0; i < 300; i++) pending_reqs.push_back(random_req());
    wait_idle();
    run_random(400, 16'd2);

    $display("run covered %0d request beats and %0d result beats over six settings",
             beats_in, beats_out);
    $display("table: %0d sampled, %0d overflow class, %0d use-after-free class",
             sampled_total, overflow_total, uaf_total);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/gsa_pkg.sv
sv/gsa_in_if.sv
sv/gsa_ctrl.sv
sv/gsa_dp.sv
sv/guard_slot_allocator.sv
dv/tb_top.sv
